// ===== rtl/twsc_pkg.sv =====
// Shared types, codes and constants for the two-wire sound command sender.
`default_nettype none
package twsc_pkg;

	localparam int WORD_BITS = 16;
	localparam int BITS_W    = $clog2(WORD_BITS + 1);
	localparam int LEN_W     = 16;
	localparam logic [LEN_W-1:0] BUSY_TICKS = 16'd20000;

	// input kinds carried on s_tuser
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_PLAY = 1'b1;

	// configuration register indexes
	localparam logic [2:0] CFG_MODE    = 3'd0;
	localparam logic [2:0] CFG_START   = 3'd1;
	localparam logic [2:0] CFG_HIGH_A  = 3'd2;
	localparam logic [2:0] CFG_LOW_A   = 3'd3;
	localparam logic [2:0] CFG_SETUP_B = 3'd4;
	localparam logic [2:0] CFG_HOLD_B  = 3'd5;
	localparam logic [2:0] CFG_HIGH_B  = 3'd6;
	localparam logic [2:0] CFG_GAP_B   = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_START   = 3'd1,
		PH_A_HIGH  = 3'd2,
		PH_A_LOW   = 3'd3,
		PH_B_SETUP = 3'd4,
		PH_B_HOLD  = 3'd5,
		PH_B_HIGH  = 3'd6,
		PH_B_WAIT  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_RUN  = 2'd0,
		SEQ_PRE  = 2'd1,
		SEQ_EMIT = 2'd2,
		SEQ_POST = 2'd3
	} seq_t;

	typedef struct packed {
		phase_t                 phase;
		logic [LEN_W-1:0]       timer;
		logic [WORD_BITS-1:0]   shift;
		logic [BITS_W-1:0]      bits;
		logic                   clk_lv;
		logic                   data_lv;
		logic                   held_valid;
	} line_st_t;

	typedef struct packed {
		logic             mode;
		logic [LEN_W-1:0] start_len;
		logic [LEN_W-1:0] high_len_a;
		logic [LEN_W-1:0] low_len_a;
		logic [LEN_W-1:0] setup_len_b;
		logic [LEN_W-1:0] hold_len_b;
		logic [LEN_W-1:0] high_len_b;
		logic [LEN_W-1:0] gap_len_b;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/two_wire_sound_command_sender.sv =====
// A result is registered at the edge that accepts its item; a tick that opens a send with
// a zero start pulse gets its result from the emit step, after the zero-length phases are
// skipped and once the output slot is free. Throughput: one item per cycle while the output
// slot is free, except that s_tready also drops while a phase that has run out is left and
// any zero-length phases right after it are skipped, and while a zero start pulse settles.
// Reset: clock and data lines high, no track held, registers at their defaults.
`default_nettype none
module two_wire_sound_command_sender (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [2:0]                     cfg_index,
	input  wire  [twsc_pkg::LEN_W-1:0]     cfg_data,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [15:0]                    s_tdata,   // [15:0] track
	input  wire                            s_tuser,   // [0] opcode
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [7:0]                     m_tdata    // [0] clk_line, [1] data_line, [2] busy_res
);
	import twsc_pkg::*;

	cfg_t      cfg_q;
	line_st_t  st_q, st_n;
	logic [15:0] held_q, held_n;
	logic      pending_q, pend_n;
	seq_t      seq_q, seq_n;
	logic      m_tvalid_q;
	logic [2:0] out_q, out_n;
	logic      out_load, slot_free, take;

	// Leave the current phase and enter the next one.
	function automatic line_st_t finish_phase(input line_st_t s, input cfg_t c);
		line_st_t r;
		r = s;
		case (s.phase)
			PH_START: begin
				if (c.mode) begin
					r.phase = PH_B_SETUP; r.clk_lv = 1'b0; r.timer = c.setup_len_b;
				end else begin
					r.phase = PH_A_HIGH; r.clk_lv = 1'b1; r.data_lv = s.shift[WORD_BITS-1];
					r.timer = c.high_len_a;
				end
			end
			PH_A_HIGH: begin
				r.phase = PH_A_LOW; r.clk_lv = 1'b0; r.timer = c.low_len_a;
			end
			PH_A_LOW: begin
				r.bits  = s.bits - 1'b1;
				r.shift = s.shift << 1;
				if (r.bits != '0) begin
					r.phase = PH_A_HIGH; r.clk_lv = 1'b1; r.data_lv = r.shift[WORD_BITS-1];
					r.timer = c.high_len_a;
				end else begin
					r.clk_lv = 1'b1; r.data_lv = 1'b1;
					r.phase = PH_IDLE; r.timer = '0; r.held_valid = 1'b0;
				end
			end
			PH_B_SETUP: begin
				r.phase = PH_B_HOLD; r.data_lv = s.shift[WORD_BITS-1]; r.timer = c.hold_len_b;
			end
			PH_B_HOLD: begin
				r.phase = PH_B_HIGH; r.clk_lv = 1'b1; r.timer = c.high_len_b;
			end
			PH_B_HIGH: begin
				r.bits  = s.bits - 1'b1;
				r.shift = s.shift << 1;
				r.phase = PH_B_WAIT;
				r.timer = (r.bits != '0) ? c.gap_len_b : BUSY_TICKS;
			end
			PH_B_WAIT: begin
				if (s.bits != '0) begin
					r.phase = PH_B_SETUP; r.clk_lv = 1'b0; r.timer = c.setup_len_b;
				end else begin
					r.phase = PH_IDLE; r.timer = '0; r.held_valid = 1'b0;
				end
			end
			default: begin
				r.phase = PH_IDLE; r.timer = '0; r.held_valid = 1'b0;
			end
		endcase
		return r;
	endfunction

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (seq_q == SEQ_RUN) && slot_free;
	assign take      = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {5'd0, out_q};

	always_comb begin
		st_n     = st_q;
		held_n   = held_q;
		pend_n   = pending_q;
		seq_n    = seq_q;
		out_load = 1'b0;
		out_n    = {pending_q || (st_q.phase != PH_IDLE), st_q.data_lv, st_q.clk_lv};
		case (seq_q)
			SEQ_RUN: begin
				if (take) begin
					if (s_tuser == OP_PLAY) begin
						if (st_q.phase == PH_IDLE && (!st_q.held_valid || held_q != s_tdata)) begin
							held_n          = s_tdata;
							st_n.held_valid = 1'b1;
							pend_n          = 1'b1;
						end
						out_load = 1'b1;
						out_n    = {pend_n || (st_q.phase != PH_IDLE), st_q.data_lv, st_q.clk_lv};
					end else if (st_q.phase == PH_IDLE && pending_q) begin
						// start a send; a zero start pulse settles before the result
						pend_n       = 1'b0;
						st_n.shift   = held_q[WORD_BITS-1:0];
						st_n.bits    = BITS_W'(WORD_BITS);
						st_n.phase   = PH_START;
						st_n.clk_lv  = 1'b0;
						st_n.data_lv = cfg_q.mode ? st_q.data_lv : 1'b0;
						st_n.timer   = cfg_q.start_len;
						if (cfg_q.start_len == '0) begin
							seq_n = SEQ_PRE;
						end else begin
							out_load   = 1'b1;
							out_n      = {1'b1, st_n.data_lv, 1'b0};
							st_n.timer = cfg_q.start_len - 1'b1;
							if (cfg_q.start_len == LEN_W'(1))
								seq_n = SEQ_POST;
						end
					end else begin
						out_load = 1'b1;
						if (st_q.phase != PH_IDLE) begin
							st_n.timer = st_q.timer - 1'b1;
							if (st_q.timer == LEN_W'(1))
								seq_n = SEQ_POST;
						end
					end
				end
			end
			SEQ_PRE: begin
				st_n = finish_phase(st_q, cfg_q);
				if (st_n.phase == PH_IDLE || st_n.timer != '0)
					seq_n = SEQ_EMIT;
			end
			SEQ_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					seq_n    = SEQ_RUN;
					if (st_q.phase != PH_IDLE) begin
						st_n.timer = st_q.timer - 1'b1;
						if (st_q.timer == LEN_W'(1))
							seq_n = SEQ_POST;
					end
				end
			end
			SEQ_POST: begin
				st_n = finish_phase(st_q, cfg_q);
				if (st_n.phase == PH_IDLE || st_n.timer != '0)
					seq_n = SEQ_RUN;
			end
			default: seq_n = SEQ_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.timer      <= '0;
			st_q.shift      <= '0;
			st_q.bits       <= '0;
			st_q.clk_lv     <= 1'b1;
			st_q.data_lv    <= 1'b1;
			st_q.held_valid <= 1'b0;
			held_q          <= '0;
			pending_q       <= 1'b0;
			seq_q           <= SEQ_RUN;
			m_tvalid_q      <= 1'b0;
		end else begin
			st_q      <= st_n;
			held_q    <= held_n;
			pending_q <= pend_n;
			seq_q     <= seq_n;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= 1'b0;
			cfg_q.start_len   <= 16'd2000;
			cfg_q.high_len_a  <= 16'd200;
			cfg_q.low_len_a   <= 16'd200;
			cfg_q.setup_len_b <= 16'd50;
			cfg_q.hold_len_b  <= 16'd50;
			cfg_q.high_len_b  <= 16'd100;
			cfg_q.gap_len_b   <= 16'd2000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:    cfg_q.mode        <= cfg_data[0];
				CFG_START:   cfg_q.start_len   <= cfg_data;
				CFG_HIGH_A:  cfg_q.high_len_a  <= cfg_data;
				CFG_LOW_A:   cfg_q.low_len_a   <= cfg_data;
				CFG_SETUP_B: cfg_q.setup_len_b <= cfg_data;
				CFG_HOLD_B:  cfg_q.hold_len_b  <= cfg_data;
				CFG_HIGH_B:  cfg_q.high_len_b  <= cfg_data;
				CFG_GAP_B:   cfg_q.gap_len_b   <= cfg_data;
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_post_expired: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_POST |-> (st_q.phase != PH_IDLE && st_q.timer == '0))
		else $error("settle pass entered without an expired phase");

	a_run_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SEQ_RUN && st_q.phase != PH_IDLE) |-> st_q.timer != '0)
		else $error("active phase with zero timer while taking requests");

	a_no_pending_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase != PH_IDLE |-> !pending_q)
		else $error("pending request while a send is in progress");

	a_bits_live: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_START || st_q.phase == PH_A_HIGH || st_q.phase == PH_A_LOW ||
		 st_q.phase == PH_B_SETUP || st_q.phase == PH_B_HOLD || st_q.phase == PH_B_HIGH)
		|-> st_q.bits != '0)
		else $error("bit phase with no bits left");

	a_result_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OP_PLAY) |=> m_tvalid)
		else $error("play request gave no result");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_two_wire_sound_command_sender.sv =====
// Self-checking bench for the two-wire sound command sender: random stream traffic, line predictor.
`timescale 1ns / 100ps
module tb_two_wire_sound_command_sender;
	import twsc_pkg::*;

	localparam int QUIET_CYCLES = 16;
	localparam int TAIL_CYCLES  = 20;

	typedef enum logic [1:0] {
		DO_ITEM  = 2'd0,
		DO_WRITE = 2'd1,
		DO_DRAIN = 2'd2
	} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		logic        op;
		logic [15:0] word;
		logic [2:0]  idx;
	} step_t;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [2:0]        cfg_index = CFG_MODE;
	logic [LEN_W-1:0]  cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata   = '0;   // [15:0] track
	logic              s_tuser   = OP_TICK;  // [0] opcode
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [7:0]        m_tdata;   // [0] clk_line, [1] data_line, [2] busy_res

	two_wire_sound_command_sender dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// line predictor state
	cfg_t                 line_cfg;
	phase_t               line_phase;
	logic [LEN_W-1:0]     line_timer;
	logic [WORD_BITS-1:0] line_shift;
	logic [BITS_W-1:0]    line_bits;
	logic [15:0]          held_track;
	logic                 held_valid;
	logic                 play_pending;
	logic                 clk_lv;
	logic                 data_lv;

	step_t       plan[$];
	logic [7:0]  line_expect[$];

	logic        holding_item;
	logic        cur_op;
	logic [15:0] cur_track;
	int          burst_left;
	int          gap_left;
	int          quiet_cnt;

	int items_sent;
	int plays_sent;
	int sends_started;
	int writes_done;
	int results_checked;
	int miss_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("two_wire_sound_command_sender verification failed");
		$finish;
	end

	task automatic close_send();
		line_phase = PH_IDLE;
		line_timer = '0;
		held_valid = 1'b0;
	endtask

	task automatic leave_phase();
		case (line_phase)
			PH_START: begin
				if (line_cfg.mode) begin
					line_phase = PH_B_SETUP;
					clk_lv = 1'b0;
					line_timer = line_cfg.setup_len_b;
				end else begin
					line_phase = PH_A_HIGH;
					clk_lv = 1'b1;
					data_lv = line_shift[WORD_BITS-1];
					line_timer = line_cfg.high_len_a;
				end
			end
			PH_A_HIGH: begin
				line_phase = PH_A_LOW;
				clk_lv = 1'b0;
				line_timer = line_cfg.low_len_a;
			end
			PH_A_LOW: begin
				line_bits = line_bits - 1'b1;
				line_shift = line_shift << 1;
				if (line_bits != 0) begin
					line_phase = PH_A_HIGH;
					clk_lv = 1'b1;
					data_lv = line_shift[WORD_BITS-1];
					line_timer = line_cfg.high_len_a;
				end else begin
					clk_lv = 1'b1;
					data_lv = 1'b1;
					close_send();
				end
			end
			PH_B_SETUP: begin
				line_phase = PH_B_HOLD;
				data_lv = line_shift[WORD_BITS-1];
				line_timer = line_cfg.hold_len_b;
			end
			PH_B_HOLD: begin
				line_phase = PH_B_HIGH;
				clk_lv = 1'b1;
				line_timer = line_cfg.high_len_b;
			end
			PH_B_HIGH: begin
				line_bits = line_bits - 1'b1;
				line_shift = line_shift << 1;
				line_phase = PH_B_WAIT;
				line_timer = (line_bits != 0) ? line_cfg.gap_len_b : BUSY_TICKS;
			end
			PH_B_WAIT: begin
				if (line_bits != 0) begin
					line_phase = PH_B_SETUP;
					clk_lv = 1'b0;
					line_timer = line_cfg.setup_len_b;
				end else begin
					close_send();
				end
			end
			default: close_send();
		endcase
	endtask

	// skip every phase that has run out, zero-length ones included
	task automatic settle_line();
		while (line_phase != PH_IDLE && line_timer == 0)
			leave_phase();
	endtask

	task automatic step_line(input logic op, input logic [15:0] trk, output logic [2:0] lv);
		logic ticking;
		ticking = 1'b0;
		if (op == OP_PLAY) begin
			if (line_phase == PH_IDLE && (!held_valid || held_track != trk)) begin
				held_track = trk;
				held_valid = 1'b1;
				play_pending = 1'b1;
			end
		end else begin
			if (line_phase == PH_IDLE && play_pending) begin
				play_pending = 1'b0;
				line_shift = held_track;
				line_bits = BITS_W'(WORD_BITS);
				line_phase = PH_START;
				clk_lv = 1'b0;
				if (!line_cfg.mode)
					data_lv = 1'b0;
				line_timer = line_cfg.start_len;
				sends_started++;
				settle_line();
			end
			ticking = 1'b1;
		end
		lv = {play_pending || line_phase != PH_IDLE, data_lv, clk_lv};
		if (ticking && line_phase != PH_IDLE) begin
			line_timer = line_timer - 1'b1;
			settle_line();
		end
	endtask

	task automatic apply_setting(input logic [2:0] idx, input logic [15:0] val);
		case (idx)
			CFG_MODE:    line_cfg.mode = val[0];
			CFG_START:   line_cfg.start_len = val;
			CFG_HIGH_A:  line_cfg.high_len_a = val;
			CFG_LOW_A:   line_cfg.low_len_a = val;
			CFG_SETUP_B: line_cfg.setup_len_b = val;
			CFG_HOLD_B:  line_cfg.hold_len_b = val;
			CFG_HIGH_B:  line_cfg.high_len_b = val;
			CFG_GAP_B:   line_cfg.gap_len_b = val;
			default: ;
		endcase
	endtask

	task automatic add_item(input logic op, input logic [15:0] trk);
		step_t s;
		s.kind = DO_ITEM;
		s.op = op;
		s.word = trk;
		s.idx = CFG_MODE;
		plan.push_back(s);
	endtask

	task automatic add_ticks(input int n);
		for (int k = 0; k < n; k++)
			add_item(OP_TICK, 16'($urandom));
	endtask

	task automatic add_write(input logic [2:0] idx, input logic [15:0] val);
		step_t s;
		s.kind = DO_WRITE;
		s.op = OP_TICK;
		s.word = val;
		s.idx = idx;
		plan.push_back(s);
	endtask

	task automatic add_drain();
		step_t s;
		s.kind = DO_DRAIN;
		s.op = OP_TICK;
		s.word = '0;
		s.idx = CFG_MODE;
		plan.push_back(s);
	endtask

	function automatic logic [15:0] pick_track(input logic [15:0] prev);
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return prev;
			default: return 16'($urandom);
		endcase
	endfunction

	// request driver: bursts of items with random gaps, register writes and drain pauses
	always @(posedge clk or negedge arst_n) begin : drive_proc
		step_t      nxt;
		logic [2:0] lv;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= OP_TICK;
			cfg_we <= 1'b0;
			cfg_index <= CFG_MODE;
			cfg_data <= '0;
			holding_item = 1'b0;
			burst_left = 1;
			gap_left = 0;
			quiet_cnt = 0;
		end else begin
			cfg_we <= 1'b0;
			if (s_tvalid && s_tready) begin
				step_line(cur_op, cur_track, lv);
				line_expect.push_back({5'd0, lv});
				items_sent++;
				if (cur_op == OP_PLAY)
					plays_sent++;
				holding_item = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
			if (!holding_item && plan.size() != 0) begin
				nxt = plan[0];
				case (nxt.kind)
					DO_ITEM: begin
						if (gap_left > 0) begin
							gap_left--;
						end else begin
							void'(plan.pop_front());
							holding_item = 1'b1;
							cur_op = nxt.op;
							cur_track = nxt.word;
							s_tuser <= nxt.op;
							s_tdata <= nxt.word;
						end
					end
					DO_WRITE: begin
						void'(plan.pop_front());
						cfg_we <= 1'b1;
						cfg_index <= nxt.idx;
						cfg_data <= nxt.word;
						apply_setting(nxt.idx, nxt.word);
						writes_done++;
					end
					default: begin
						// hold until every result is in, then let the sequencer settle
						if (line_expect.size() == 0) begin
							if (quiet_cnt >= QUIET_CYCLES) begin
								void'(plan.pop_front());
								quiet_cnt = 0;
							end else begin
								quiet_cnt++;
							end
						end else begin
							quiet_cnt = 0;
						end
					end
				endcase
			end
			s_tvalid <= holding_item;
		end
	end

	// result receiver: stall pattern of its own plus a periodic long hold-off
	always @(posedge clk or negedge arst_n) begin : rx_proc
		int rx_cyc;
		int rx_hold;
		int rx_span;
		int rx_pct;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cyc = 0;
			rx_hold = 0;
			rx_span = 0;
			rx_pct = 0;
		end else begin
			rx_cyc++;
			if (rx_cyc % 600 == 300)
				rx_hold = $urandom_range(60, 120);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				if (rx_span == 0) begin
					rx_span = $urandom_range(5, 60);
					case ($urandom_range(0, 2))
						0: rx_pct = 0;
						1: rx_pct = 30;
						default: rx_pct = 70;
					endcase
				end
				rx_span--;
				m_tready <= ($urandom_range(0, 99) >= rx_pct);
			end
		end
	end

	always @(posedge clk) begin : mon_proc
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (line_expect.size() == 0) begin
				miss_cnt++;
				if (miss_cnt <= 10)
					$display("unexpected line result %b", m_tdata);
			end else begin
				want = line_expect.pop_front();
				if (m_tdata[0] !== want[0] || m_tdata[1] !== want[1] ||
				    m_tdata[2] !== want[2] || m_tdata[7:3] !== want[7:3]) begin
					miss_cnt++;
					if (miss_cnt <= 10)
						$display({"result %0d exp/got: clk_line %b/%b data_line %b/%b",
						          " busy_res %b/%b pad %b/%b"}, results_checked,
						         want[0], m_tdata[0], want[1], m_tdata[1],
						         want[2], m_tdata[2], want[7:3], m_tdata[7:3]);
				end
				results_checked++;
			end
		end
	end

	initial begin : stim_proc
		int          st;
		int          hi;
		int          lo;
		int          su;
		int          ho;
		int          hb;
		int          gp;
		int          full;
		int          n;
		int          mark;
		logic [15:0] last_trk;

		line_cfg.mode = 1'b0;
		line_cfg.start_len = 16'd2000;
		line_cfg.high_len_a = 16'd200;
		line_cfg.low_len_a = 16'd200;
		line_cfg.setup_len_b = 16'd50;
		line_cfg.hold_len_b = 16'd50;
		line_cfg.high_len_b = 16'd100;
		line_cfg.gap_len_b = 16'd2000;
		line_phase = PH_IDLE;
		line_timer = '0;
		line_shift = '0;
		line_bits = '0;
		held_track = '0;
		held_valid = 1'b0;
		play_pending = 1'b0;
		clk_lv = 1'b1;
		data_lv = 1'b1;
		items_sent = 0;
		plays_sent = 0;
		sends_started = 0;
		writes_done = 0;
		results_checked = 0;
		miss_cnt = 0;
		last_trk = 16'h0000;

		// mode 0, shortest phases; unused mode 1 lengths at their top
		add_write(CFG_MODE, 16'd0);
		add_write(CFG_START, 16'd1);
		add_write(CFG_HIGH_A, 16'd1);
		add_write(CFG_LOW_A, 16'd1);
		add_write(CFG_SETUP_B, 16'hFFFF);
		add_write(CFG_HOLD_B, 16'hFFFF);
		add_write(CFG_HIGH_B, 16'hFFFF);
		add_write(CFG_GAP_B, 16'hFFFF);
		add_ticks(1);
		add_item(OP_PLAY, 16'h0000);   // latched: nothing held yet
		add_item(OP_PLAY, 16'h0000);   // same track, dropped
		add_item(OP_PLAY, 16'hFFFF);   // replaces the pending track
		add_ticks(1);
		add_item(OP_PLAY, 16'h1234);   // busy, dropped
		add_ticks(36);

		// send opens in mode 1, mode flips to 0 during the start pulse
		add_drain();
		add_write(CFG_MODE, 16'd1);
		add_write(CFG_START, 16'd3);
		add_write(CFG_HIGH_A, 16'd1);
		add_write(CFG_LOW_A, 16'd2);
		add_item(OP_PLAY, 16'h1234);
		add_ticks(1);
		add_drain();
		add_write(CFG_MODE, 16'd0);
		add_ticks(60);

		// random mode 0 phases
		for (int p = 0; p < 4; p++) begin
			st = (p == 0) ? 1 : $urandom_range(1, 5);
			hi = (p == 0) ? 1 : $urandom_range(1, 2);
			lo = (p == 0) ? 1 : $urandom_range(1, 2);
			add_drain();
			add_write(CFG_MODE, 16'd0);
			add_write(CFG_START, 16'(st));
			add_write(CFG_HIGH_A, 16'(hi));
			add_write(CFG_LOW_A, 16'(lo));
			add_write(CFG_SETUP_B, 16'($urandom));
			add_write(CFG_HOLD_B, 16'($urandom));
			add_write(CFG_HIGH_B, 16'($urandom));
			add_write(CFG_GAP_B, 16'($urandom));
			full = st + WORD_BITS * (hi + lo);
			mark = plan.size();
			while (plan.size() - mark < 35) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						last_trk = pick_track(last_trk);
						add_item(OP_PLAY, last_trk);
						if ($urandom_range(0, 3) == 0)
							add_item(OP_PLAY, last_trk);
						n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, full)
						                                 : full + $urandom_range(0, 4);
						for (int k = 0; k < n; k++) begin
							if ($urandom_range(0, 14) == 0)
								add_item(OP_PLAY, pick_track(last_trk));
							add_item(OP_TICK, 16'($urandom));
						end
					end
					6, 7: add_item(OP_PLAY, pick_track(last_trk));
					default: add_ticks($urandom_range(1, 8));
				endcase
			end
		end

		// random mode 1 send, opened in mode 0 and flipped to mode 1 during the
		// start pulse; left in the busy wait at the end
		st = $urandom_range(2, 4);
		su = $urandom_range(1, 2);
		ho = $urandom_range(1, 2);
		hb = $urandom_range(1, 2);
		gp = $urandom_range(0, 2);
		add_drain();
		add_write(CFG_MODE, 16'd0);
		add_write(CFG_START, 16'(st));
		add_write(CFG_SETUP_B, 16'(su));
		add_write(CFG_HOLD_B, 16'(ho));
		add_write(CFG_HIGH_B, 16'(hb));
		add_write(CFG_GAP_B, 16'(gp));
		add_write(CFG_HIGH_A, 16'($urandom));
		add_write(CFG_LOW_A, 16'($urandom));
		add_item(OP_PLAY, 16'($urandom));
		add_ticks(1);
		add_drain();
		add_write(CFG_MODE, 16'd1);
		n = st + WORD_BITS * (su + ho + hb) + (WORD_BITS - 1) * gp + 30;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0)
				add_item(OP_PLAY, 16'($urandom));
			add_item(OP_TICK, 16'($urandom));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (plan.size() != 0 || holding_item || line_expect.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d items (%0d play requests), %0d sends over both modes,",
		         items_sent, plays_sent, sends_started);
		$display("%0d register writes, %0d results checked, %0d mismatches",
		         writes_done, results_checked, miss_cnt);
		if (miss_cnt == 0 && line_expect.size() == 0)
			$display("two_wire_sound_command_sender verification clean");
		else
			$display("two_wire_sound_command_sender verification failed");
		$finish;
	end

endmodule
